// File: rtl/mvm_pkg.sv
`default_nettype none

package mvm_pkg;

	localparam int DEF_MAX_ROWS = 16;
	localparam int DEF_MAX_COLS = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int ACC_W        = 40;
	localparam int FRAC_BITS    = 12;
	localparam int PROD_W       = 32;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ACTIVE_ROWS = 2'd0;
	localparam logic [1:0] CFG_ACTIVE_COLS = 2'd1;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SAT      = 2'd1;
	localparam logic [1:0] STAT_MISMATCH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_MISMATCH
	} state_t;

	// Commands from the sequencer to the storage and MAC datapath.
	typedef struct packed {
		logic               mac_issue;
		logic               out_issue;
		logic               clear;
		logic [3:0]         row;
		logic [4:0]         col;
		logic signed [15:0] x;
		logic               wr_en;
		logic [3:0]         wr_row;
		logic [3:0]         wr_col;
		logic [15:0]        wr_data;
	} mvm_ctrl_t;

	// Status returned by the datapath.
	typedef struct packed {
		logic             busy;
		logic [ACC_W-1:0] acc_data;
	} mvm_stat_t;

endpackage

`default_nettype wire

// File: rtl/matrix_vector_multiply.sv
`default_nettype none

// Matrix-vector multiplier in signed Q4.12. A weight word (func 0) stores one matrix
// element at row_index, col_index. A vector word (func 1) carries the next vector
// element; it is multiplied against the stored weight of every active row, one row per
// cycle through a single 16x16 multiplier, and each row's 40-bit accumulator is read,
// updated and written back in a one-port-read, one-port-write memory. A vector word
// therefore holds the block until it is accepted, its rows are issued, and the memory
// read, multiply and write-back have drained, so that the next element cannot touch
// the same accumulator too soon. On the word marked last, the results follow one per
// row (accumulator read, then output register load), waiting while the consumer
// stalls; a length mismatch gives a single word instead. The output register lets the
// block accept the next input word while the final result waits.
// Results are the accumulator shifted right by 12 and saturated to 16 bits, with status
// showing saturation. Accumulators need no clearing pass after reset; the weight memory
// holds garbage until written, and every weight that a vector reads must be written first.
// Configuration must be written only while the block is idle; it is not enforced.

module matrix_vector_multiply #(
	parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [4:0]         cfg_data,

	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [3:0]         row_index,
	input  wire logic [3:0]         col_index,
	input  wire logic signed [15:0] value,
	input  wire logic               last,

	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              out_row,
	output logic signed [15:0]      out_value,
	output logic [1:0]              status,
	output logic                    out_last
);
	import mvm_pkg::*;

	localparam int RLIM = (MAX_ROWS < RESULT_LIMIT) ? MAX_ROWS : RESULT_LIMIT;

	state_t    state_q, state_d;
	mvm_ctrl_t ctrl;
	mvm_stat_t stat;

	logic [4:0] act_rows_q;
	logic [4:0] act_cols_q;
	logic [4:0] eff_rows;
	logic [4:0] eff_cols;
	logic [3:0] last_row;

	logic [4:0]         cnt_q;
	logic [4:0]         col_q;
	logic signed [15:0] x_q;
	logic               last_q;
	logic [3:0]         row_q;
	logic [3:0]         orow_q;

	logic in_fire;
	logic out_free;
	logic mac_issue;
	logic out_issue;
	logic clear;
	logic load_out;
	logic load_mis;

	logic [ACC_W-FRAC_BITS-1:0] shifted;
	logic                       sat;
	logic [15:0]                sat_value;

	logic               out_valid_q;
	logic [3:0]         out_row_q;
	logic signed [15:0] out_value_q;
	logic [1:0]         status_q;
	logic               out_last_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Registers are clamped to the rows and columns the storage holds; zero reads as one.
	always_comb begin
		if (act_rows_q == 5'd0) begin
			eff_rows = 5'd1;
		end else if (int'(act_rows_q) > RLIM) begin
			eff_rows = 5'(RLIM);
		end else begin
			eff_rows = act_rows_q;
		end
		if (act_cols_q == 5'd0) begin
			eff_cols = 5'd1;
		end else if (int'(act_cols_q) > MAX_COLS) begin
			eff_cols = 5'(MAX_COLS);
		end else begin
			eff_cols = act_cols_q;
		end
	end

	assign last_row = 4'(eff_rows - 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_rows_q <= 5'd16;
			act_cols_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACTIVE_ROWS: act_rows_q <= cfg_data;
				CFG_ACTIVE_COLS: act_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: row issue per element, drain, and after the last one readout or mismatch.
	always_comb begin
		state_d   = state_q;
		mac_issue = 1'b0;
		out_issue = 1'b0;
		clear     = 1'b0;
		load_out  = 1'b0;
		load_mis  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && func) begin
					// Elements past the column count are counted but not accumulated.
					state_d = (cnt_q < eff_cols) ? ST_MAC : ST_DRAIN;
				end
			end
			ST_MAC: begin
				mac_issue = 1'b1;
				if (row_q == last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					if (!last_q) begin
						state_d = ST_IDLE;
					end else if (cnt_q == eff_cols) begin
						state_d = ST_OUT_RD;
					end else begin
						state_d = ST_MISMATCH;
					end
				end
			end
			ST_OUT_RD: begin
				// The read data lands next cycle, when the output register is free.
				if (out_free) begin
					out_issue = 1'b1;
					clear     = (orow_q == last_row);
					state_d   = ST_OUT_LD;
				end
			end
			ST_OUT_LD: begin
				load_out = 1'b1;
				state_d  = (orow_q == last_row) ? ST_IDLE : ST_OUT_RD;
			end
			ST_MISMATCH: begin
				if (out_free) begin
					load_mis = 1'b1;
					clear    = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
			row_q  <= '0;
			orow_q <= '0;
		end else begin
			if (clear) begin
				cnt_q <= '0;
			end else if (in_fire && func && cnt_q != 5'd31) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (in_fire && func) begin
				last_q <= last;
				row_q  <= '0;
			end else if (mac_issue) begin
				row_q <= row_q + 4'd1;
			end
			if (state_q == ST_DRAIN) begin
				orow_q <= '0;
			end else if (load_out) begin
				orow_q <= orow_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && func) begin
			x_q   <= value;
			col_q <= cnt_q;
		end
	end

	assign ctrl.mac_issue = mac_issue;
	assign ctrl.out_issue = out_issue;
	assign ctrl.clear     = clear;
	assign ctrl.row       = (state_q == ST_OUT_RD) ? orow_q : row_q;
	assign ctrl.col       = col_q;
	assign ctrl.x         = x_q;
	assign ctrl.wr_en     = in_fire && !func;
	assign ctrl.wr_row    = row_index;
	assign ctrl.wr_col    = col_index;
	assign ctrl.wr_data   = value;

	mvm_store #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.stat  (stat)
	);

	// Drop the fraction bits (floor), then saturate the 28-bit value to 16 bits.
	assign shifted = stat.acc_data[ACC_W-1:FRAC_BITS];
	assign sat = !((&shifted[ACC_W-FRAC_BITS-1:15]) || !(|shifted[ACC_W-FRAC_BITS-1:15]));
	assign sat_value = !sat ? shifted[15:0] :
		(shifted[ACC_W-FRAC_BITS-1] ? 16'h8000 : 16'h7FFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out || load_mis) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_row_q   <= orow_q;
			out_value_q <= sat_value;
			status_q    <= sat ? STAT_SAT : STAT_OK;
			out_last_q  <= (orow_q == last_row);
		end else if (load_mis) begin
			out_row_q   <= '0;
			out_value_q <= '0;
			status_q    <= STAT_MISMATCH;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign out_last  = out_last_q;

	// A result is loaded only after the previous word has left the output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT_LD |-> !out_valid_q)
		else $error("output register overwritten while a word was pending");

	// The MAC pipeline has written back every row before the sequencer moves on.
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN && state_d != ST_DRAIN |-> !stat.busy)
		else $error("left drain with accumulator writes in flight");

	// No new word is taken while accumulator updates are still in flight.
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.busy)
		else $error("input accepted during accumulator update");

	// A mismatch word is the only result of its vector.
	a_mismatch_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_MISMATCH |-> out_last && out_row == 4'd0)
		else $error("malformed length mismatch word");

	// Readout issue and row issue never happen together.
	a_issue_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.mac_issue && ctrl.out_issue))
		else $error("accumulator read port requested twice");

endmodule

`default_nettype wire

// File: rtl/mvm_store.sv
`default_nettype none

module mvm_store #(
	parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mvm_pkg::mvm_ctrl_t ctrl,
	output mvm_pkg::mvm_stat_t     stat
);
	import mvm_pkg::*;

	localparam int WDEPTH = MAX_ROWS * MAX_COLS;
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int ADEPTH = (MAX_ROWS < RESULT_LIMIT) ? MAX_ROWS : RESULT_LIMIT;
	localparam int AW     = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;

	logic [15:0]      weight_mem [WDEPTH];
	logic [ACC_W-1:0] acc_mem    [ADEPTH];
	logic [ADEPTH-1:0] acc_vld_q;

	logic [WAW-1:0] waddr;
	logic [WAW-1:0] raddr;
	logic [AW-1:0]  aidx;
	logic           wr_in_range;

	logic signed [15:0] w_rd_s1;
	logic [ACC_W-1:0]   acc_rd_s1;
	logic               acc_hit_s1;
	logic               mac_s1;
	logic [AW-1:0]      row_s1;

	logic signed [PROD_W-1:0] prod_s2;
	logic [ACC_W-1:0]         acc_s2;
	logic                     mac_s2;
	logic [AW-1:0]            row_s2;
	logic [ACC_W-1:0]         sum_s2;

	assign wr_in_range = (int'(ctrl.wr_row) < MAX_ROWS) && (int'(ctrl.wr_col) < MAX_COLS);
	assign waddr = WAW'(int'(ctrl.wr_row) * MAX_COLS + int'(ctrl.wr_col));
	assign raddr = WAW'(int'(ctrl.row) * MAX_COLS + int'(ctrl.col));
	assign aidx  = ctrl.row[AW-1:0];

	// Weight memory: one write port for weight items, one read port for the MAC.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en && wr_in_range) begin
			weight_mem[waddr] <= ctrl.wr_data;
		end
		if (ctrl.mac_issue) begin
			w_rd_s1 <= weight_mem[raddr];
		end
	end

	// Accumulator memory: read for the MAC or for result readout, written back by the MAC.
	always_ff @(posedge clk) begin
		if (ctrl.mac_issue || ctrl.out_issue) begin
			acc_rd_s1 <= acc_mem[aidx];
		end
		if (mac_s2) begin
			acc_mem[row_s2] <= sum_s2;
		end
	end

	// An accumulator row that has not been written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q  <= '0;
			acc_hit_s1 <= 1'b0;
		end else begin
			if (ctrl.mac_issue || ctrl.out_issue) begin
				acc_hit_s1 <= acc_vld_q[aidx];
			end
			if (ctrl.clear) begin
				acc_vld_q <= '0;
			end else if (mac_s2) begin
				acc_vld_q[row_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
		end else begin
			mac_s1 <= ctrl.mac_issue;
			mac_s2 <= mac_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1  <= aidx;
		row_s2  <= row_s1;
		prod_s2 <= w_rd_s1 * ctrl.x;
		acc_s2  <= acc_hit_s1 ? acc_rd_s1 : '0;
	end

	assign sum_s2 = acc_s2 + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	assign stat.busy     = mac_s1 || mac_s2;
	assign stat.acc_data = acc_hit_s1 ? acc_rd_s1 : '0;

endmodule

`default_nettype wire
